// File: rtl/stereo_delay_mixer_defines.svh
// Assertion macros for the stereo delay mixer.
// Used by the top level. Expects clk and rst_n in scope where expanded.
`ifndef STEREO_DELAY_MIXER_DEFINES_SVH
`define STEREO_DELAY_MIXER_DEFINES_SVH

// antecedent and consequent in the same cycle
`define SDM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define SDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sdm_pkg.sv
// Shared types and constants of the stereo delay mixer.
// No dependencies; used by every other file but sdm_queue and the defines header.
`timescale 1ns / 1ps

package sdm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 10;
    localparam int DELAY_W    = 9;
    localparam int VOLUME_W   = 9;
    localparam int GAIN_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRY_LEVEL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WET_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_DELAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_VOLUME  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_VOLUME = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MONO_MODE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_WET   = 3'd7;

    // reset values
    localparam logic [LEVEL_W-1:0]  RST_DRY_LEVEL    = 10'd256;
    localparam logic [LEVEL_W-1:0]  RST_WET_LEVEL    = 10'd256;
    localparam logic [DELAY_W-1:0]  RST_LEFT_DELAY   = 9'd128;
    localparam logic [DELAY_W-1:0]  RST_RIGHT_DELAY  = 9'd160;
    localparam logic [VOLUME_W-1:0] RST_LEFT_VOLUME  = 9'd256;
    localparam logic [VOLUME_W-1:0] RST_RIGHT_VOLUME = 9'd256;

    typedef struct packed {
        logic [LEVEL_W-1:0]  dry_level;
        logic [LEVEL_W-1:0]  wet_level;
        logic [DELAY_W-1:0]  left_delay;
        logic [DELAY_W-1:0]  right_delay;
        logic [VOLUME_W-1:0] left_volume;
        logic [VOLUME_W-1:0] right_volume;
        logic                mono_mode;
        logic                invert_wet;
    } cfg_t;

    typedef struct packed {
        logic clearing;     // store clearing pass after reset
    } status_t;

    // width of one queue entry for a given store address width
    function automatic int entry_w(input int aw);
        return 2 * SAMPLE_W + 3 * aw + 2 + 2 * GAIN_W + 1;
    endfunction

endpackage

// File: rtl/sdm_in_if.sv
// Input stream channel: one stereo frame per beat.
// Depends on sdm_pkg for the sample width.
`timescale 1ns / 1ps

interface sdm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sdm_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [sdm_pkg::SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// File: rtl/sdm_out_if.sv
// Output stream channel: one mixed stereo frame per beat.
// Depends on sdm_pkg for the sample width.
`timescale 1ns / 1ps

interface sdm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sdm_pkg::SAMPLE_W-1:0] left_result;
    logic signed [sdm_pkg::SAMPLE_W-1:0] right_result;

    modport source (output valid, output left_result, output right_result, input ready);
    modport sink   (input valid, input left_result, input right_result, output ready);
endinterface

// File: rtl/sdm_front.sv
// Front end: accepts frames, tracks the write position, works out tap
// addresses and wet gains. Depends on sdm_pkg and sdm_in_if.
`timescale 1ns / 1ps

module sdm_front #(
    parameter int STORE_DEPTH = 750
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sdm_in_if.sink                samples,
    input  sdm_pkg::cfg_t         cfg,
    input  sdm_pkg::status_t      st,
    input  logic                  q_full,
    output logic                  push,
    output logic [sdm_pkg::entry_w($clog2(STORE_DEPTH))-1:0] push_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = $clog2(STORE_DEPTH + 1) + sdm_pkg::DELAY_W;
    localparam int DW = PW - 8;
    localparam int GPW = sdm_pkg::LEVEL_W + sdm_pkg::VOLUME_W;

    typedef struct packed {
        logic signed [sdm_pkg::SAMPLE_W-1:0] left_sample;
        logic signed [sdm_pkg::SAMPLE_W-1:0] right_sample;
        logic [AW-1:0]                       wr_addr;
        logic [AW-1:0]                       rd_left;
        logic [AW-1:0]                       rd_right;
        logic                                tap_zero_l;
        logic                                tap_zero_r;
        logic [sdm_pkg::GAIN_W-1:0]          gain_l;
        logic [sdm_pkg::GAIN_W-1:0]          gain_r;
        logic                                mono;
    } entry_t;

    logic [AW-1:0] wi_reg;
    logic [AW-1:0] wi_next;
    logic [AW-1:0] dist_l;
    logic [AW-1:0] dist_r;
    logic          accept;
    entry_t        entry;

    // (depth * setting) >> 8, clamped to depth-1
    function automatic logic [AW-1:0] tap_dist(input logic [sdm_pkg::DELAY_W-1:0] s);
        logic [PW-1:0] prod;
        logic [DW-1:0] full;
        prod = PW'(STORE_DEPTH) * PW'(s);
        full = prod[PW-1:8];
        if (full >= DW'(STORE_DEPTH))
            return AW'(STORE_DEPTH - 1);
        return full[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] rd_addr(input logic [AW-1:0] wi, input logic [AW-1:0] d);
        logic [AW:0] wrapped;
        wrapped = {1'b0, wi} + (AW+1)'(STORE_DEPTH) - {1'b0, d};
        if (wi >= d)
            return wi - d;
        return wrapped[AW-1:0];
    endfunction

    function automatic logic [sdm_pkg::GAIN_W-1:0] wet_gain(
        input logic [sdm_pkg::LEVEL_W-1:0]  wet,
        input logic [sdm_pkg::VOLUME_W-1:0] vol
    );
        logic [GPW-1:0] prod;
        prod = GPW'(wet) * GPW'(vol);
        return prod[GPW-1:8];
    endfunction

    assign samples.ready = !q_full && !st.clearing;
    assign accept        = samples.valid && samples.ready;

    assign dist_l = tap_dist(cfg.left_delay);
    assign dist_r = tap_dist(cfg.right_delay);

    always_comb
    begin
        entry.left_sample  = samples.left_sample;
        entry.right_sample = samples.right_sample;
        entry.wr_addr      = wi_reg;
        entry.rd_left      = rd_addr(wi_reg, dist_l);
        entry.rd_right     = rd_addr(wi_reg, dist_r);
        entry.tap_zero_l   = (dist_l == '0);
        entry.tap_zero_r   = (dist_r == '0);
        entry.gain_l       = wet_gain(cfg.wet_level, cfg.left_volume);
        entry.gain_r       = wet_gain(cfg.wet_level, cfg.right_volume);
        entry.mono         = cfg.mono_mode;
    end

    assign push      = accept;
    assign push_data = entry;

    always_comb
    begin
        wi_next = wi_reg;
        if (accept)
        begin
            if (wi_reg == AW'(STORE_DEPTH - 1))
                wi_next = '0;
            else
                wi_next = wi_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wi_reg <= '0;
        else
            wi_reg <= wi_next;
    end

endmodule

// File: rtl/sdm_queue.sv
// Short FIFO between front and back ends.
// No package dependency.
`timescale 1ns / 1ps

module sdm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    function automatic logic [PTRW-1:0] bump(input logic [PTRW-1:0] p);
        if (p == PTRW'(DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/sdm_back.sv
// Back end: delay stores, wet/dry multiply, saturation, output register.
// Also runs the store clearing pass after reset. Depends on sdm_pkg, sdm_out_if.
`timescale 1ns / 1ps

module sdm_back #(
    parameter int STORE_DEPTH = 750
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sdm_pkg::cfg_t         cfg,
    input  logic                  q_valid,
    input  logic [sdm_pkg::entry_w($clog2(STORE_DEPTH))-1:0] q_head,
    output logic                  pop,
    output sdm_pkg::status_t      st,
    sdm_out_if.source             results
);

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int SW  = sdm_pkg::SAMPLE_W;
    localparam int WPW = SW + sdm_pkg::GAIN_W + 1;
    localparam int DPW = SW + sdm_pkg::LEVEL_W + 1;

    typedef struct packed {
        logic signed [SW-1:0]       left_sample;
        logic signed [SW-1:0]       right_sample;
        logic [AW-1:0]              wr_addr;
        logic [AW-1:0]              rd_left;
        logic [AW-1:0]              rd_right;
        logic                       tap_zero_l;
        logic                       tap_zero_r;
        logic [sdm_pkg::GAIN_W-1:0] gain_l;
        logic [sdm_pkg::GAIN_W-1:0] gain_r;
        logic                       mono;
    } entry_t;

    entry_t e;

    logic signed [SW-1:0] left_store  [STORE_DEPTH];
    logic signed [SW-1:0] right_store [STORE_DEPTH];

    logic                 clr_active_reg;
    logic [AW-1:0]        clr_idx_reg;

    logic                 adv;
    logic                 we_l;
    logic                 we_r;
    logic [AW-1:0]        wa;
    logic signed [SW-1:0] wd_l;
    logic signed [SW-1:0] wd_r;

    logic                 s1_v_reg;
    entry_t               s1_reg;
    logic signed [SW-1:0] rdata_l_reg;
    logic signed [SW-1:0] rdata_r_reg;
    logic signed [SW-1:0] delayed_l;
    logic signed [SW-1:0] delayed_r;

    logic                  s2_v_reg;
    logic                  s2_mono_reg;
    logic signed [WPW-1:0] wet_l_reg;
    logic signed [WPW-1:0] wet_r_reg;
    logic signed [DPW-1:0] dry_l_reg;
    logic signed [DPW-1:0] dry_r_reg;

    logic                 out_v_reg;
    logic signed [SW-1:0] left_res_reg;
    logic signed [SW-1:0] right_res_reg;
    logic signed [SW-1:0] mix_l;
    logic signed [SW-1:0] mix_r;

    // both divides by 256 truncate toward zero, then add and saturate
    function automatic logic signed [SW-1:0] mix(
        input logic signed [WPW-1:0] wp,
        input logic signed [DPW-1:0] dp,
        input logic                  inv
    );
        logic signed [WPW-1:0] wadj;
        logic signed [DPW-1:0] dadj;
        logic signed [WPW-9:0] wq;
        logic signed [DPW-9:0] dq;
        logic signed [WPW-8:0] sum;
        wadj = wp + (wp[WPW-1] ? WPW'(255) : WPW'(0));
        dadj = dp + (dp[DPW-1] ? DPW'(255) : DPW'(0));
        wq   = wadj[WPW-1:8];
        dq   = dadj[DPW-1:8];
        if (inv)
            wq = -wq;
        sum = {wq[WPW-9], wq} + {{(WPW-DPW+1){dq[DPW-9]}}, dq};
        if (sum > (WPW-7)'(32767))
            return 16'sh7fff;
        if (sum < -(WPW-7)'(32768))
            return -16'sh8000;
        return sum[SW-1:0];
    endfunction

    assign e   = q_head;
    assign adv = !out_v_reg || results.ready;
    assign pop = adv && q_valid && !clr_active_reg;

    assign st.clearing = clr_active_reg;

    // store write port: clearing pass or the incoming frame
    always_comb
    begin
        we_l = clr_active_reg || pop;
        we_r = clr_active_reg || (pop && !e.mono);
        wa   = clr_active_reg ? clr_idx_reg : e.wr_addr;
        wd_l = clr_active_reg ? '0 : e.left_sample;
        wd_r = clr_active_reg ? '0 : e.right_sample;
    end

    // tap never equals the write address unless the delay is zero,
    // which is bypassed below
    always_ff @(posedge clk)
    begin
        if (we_l)
            left_store[wa] <= wd_l;
        if (pop)
            rdata_l_reg <= left_store[e.rd_left];
    end

    always_ff @(posedge clk)
    begin
        if (we_r)
            right_store[wa] <= wd_r;
        if (pop)
            rdata_r_reg <= right_store[e.rd_right];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_idx_reg == AW'(STORE_DEPTH - 1))
                clr_active_reg <= 1'b0;
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    assign delayed_l = s1_reg.tap_zero_l ? s1_reg.left_sample  : rdata_l_reg;
    assign delayed_r = s1_reg.tap_zero_r ? s1_reg.right_sample : rdata_r_reg;

    assign mix_l = mix(wet_l_reg, dry_l_reg, cfg.invert_wet);
    assign mix_r = mix(wet_r_reg, dry_r_reg, cfg.invert_wet);

    // payload
    always_ff @(posedge clk)
    begin
        if (pop)
            s1_reg <= e;
        if (adv)
        begin
            s2_mono_reg   <= s1_reg.mono;
            wet_l_reg     <= delayed_l * $signed({1'b0, s1_reg.gain_l});
            wet_r_reg     <= delayed_r * $signed({1'b0, s1_reg.gain_r});
            dry_l_reg     <= s1_reg.left_sample  * $signed({1'b0, cfg.dry_level});
            dry_r_reg     <= s1_reg.right_sample * $signed({1'b0, cfg.dry_level});
            left_res_reg  <= mix_l;
            right_res_reg <= s2_mono_reg ? mix_l : mix_r;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= pop;
            s2_v_reg  <= s1_v_reg;
            out_v_reg <= s2_v_reg;
        end
    end

    assign results.valid        = out_v_reg;
    assign results.left_result  = left_res_reg;
    assign results.right_result = right_res_reg;

endmodule

// File: rtl/stereo_delay_mixer.sv
// Top level of the stereo delay mixer: configuration registers, front end,
// queue and back end. Depends on sdm_pkg, the interfaces and all submodules.
`timescale 1ns / 1ps
`include "stereo_delay_mixer_defines.svh"

//  channel   | kind          | payload
//  ----------+---------------+------------------------------------------
//  samples   | valid/ready   | left_sample, right_sample (16b signed)
//  results   | valid/ready   | left_result, right_result (16b signed)
//  cfg       | write enable  | cfg_index (3b), cfg_data (10b)
//
// Sustained rate is one frame per cycle while results are taken and no clearing
// pass runs, set by the single write and read port on each delay store. A frame
// passes the queue and the s1, s2 and output registers. After reset a clearing
// pass zeroes both stores; samples.ready stays low meanwhile, configuration
// writes are taken. A stalled results channel freezes the back end; the queue
// keeps taking up to QUEUE_DEPTH frames before samples.ready drops.

module stereo_delay_mixer #(
    parameter int STORE_DEPTH = 750,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sdm_in_if.sink                            samples,
    sdm_out_if.source                         results,
    input  logic                              cfg_we,
    input  logic [sdm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sdm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int EW = sdm_pkg::entry_w(AW);

    sdm_pkg::cfg_t    cfg_reg;
    sdm_pkg::status_t st;

    logic          q_push;
    logic [EW-1:0] q_push_data;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic [EW-1:0] q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dry_level    <= sdm_pkg::RST_DRY_LEVEL;
            cfg_reg.wet_level    <= sdm_pkg::RST_WET_LEVEL;
            cfg_reg.left_delay   <= sdm_pkg::RST_LEFT_DELAY;
            cfg_reg.right_delay  <= sdm_pkg::RST_RIGHT_DELAY;
            cfg_reg.left_volume  <= sdm_pkg::RST_LEFT_VOLUME;
            cfg_reg.right_volume <= sdm_pkg::RST_RIGHT_VOLUME;
            cfg_reg.mono_mode    <= 1'b0;
            cfg_reg.invert_wet   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdm_pkg::REG_DRY_LEVEL:    cfg_reg.dry_level    <= cfg_data;
                sdm_pkg::REG_WET_LEVEL:    cfg_reg.wet_level    <= cfg_data;
                sdm_pkg::REG_LEFT_DELAY:   cfg_reg.left_delay   <= cfg_data[8:0];
                sdm_pkg::REG_RIGHT_DELAY:  cfg_reg.right_delay  <= cfg_data[8:0];
                sdm_pkg::REG_LEFT_VOLUME:  cfg_reg.left_volume  <= cfg_data[8:0];
                sdm_pkg::REG_RIGHT_VOLUME: cfg_reg.right_volume <= cfg_data[8:0];
                sdm_pkg::REG_MONO_MODE:    cfg_reg.mono_mode    <= cfg_data[0];
                sdm_pkg::REG_INVERT_WET:   cfg_reg.invert_wet   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sdm_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg       (cfg_reg),
        .st        (st),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    sdm_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    sdm_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_head  (q_head),
        .pop     (q_pop),
        .st      (st),
        .results (results)
    );

    `SDM_ASSERT_NOW(a_no_push_full, q_push, !q_full, "push into a full queue")
    `SDM_ASSERT_NOW(a_no_pop_empty, q_pop, q_valid, "pop from an empty queue")
    `SDM_ASSERT_NOW(a_clear_quiet, st.clearing, !samples.ready && !results.valid, "activity during clear")
    `SDM_ASSERT_NEXT(a_clear_once, q_push, !st.clearing, "clearing pass restarted")

endmodule

// File: dv/stereo_delay_mixer_checker.sv
// Scoreboard for the stereo delay mixer: tracks the register writes, predicts each
// mixed frame from the sample beats, and compares it with the result beats.
// Depends on sdm_pkg and the sdm_in_if / sdm_out_if channel interfaces.
`timescale 1ns / 1ps

module stereo_delay_mixer_checker
    import sdm_pkg::*;
#(
    parameter int STORE_DEPTH = 750
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sdm_in_if                     samples,
    sdm_out_if                    results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } mix_frame_t;

    localparam int LEFT  = 0;
    localparam int RIGHT = 1;

    cfg_t                       regs;
    logic signed [SAMPLE_W-1:0] delay_line [2][STORE_DEPTH];
    int unsigned                wr_ptr;
    mix_frame_t                 expected_mix [$];

    function automatic logic signed [SAMPLE_W-1:0] mix_one(
        input int                         ch,
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [DELAY_W-1:0]         setting,
        input logic [VOLUME_W-1:0]        volume
    );
        int unsigned tap_len;
        int unsigned rd;
        longint      gain;
        longint      wet;
        longint      dry;
        longint      sum;
        tap_len = (STORE_DEPTH * int'(setting)) >> 8;
        if (tap_len >= STORE_DEPTH)
            tap_len = STORE_DEPTH - 1;
        // tap is read after the write, so a zero distance returns this sample
        delay_line[ch][wr_ptr] = smp;
        rd = (wr_ptr >= tap_len) ? wr_ptr - tap_len : wr_ptr + STORE_DEPTH - tap_len;
        gain = (longint'(regs.wet_level) * longint'(volume)) / 256;
        wet = (longint'(delay_line[ch][rd]) * gain) / 256;
        if (regs.invert_wet)
            wet = -wet;
        dry = (longint'(smp) * longint'(regs.dry_level)) / 256;
        sum = wet + dry;
        if (sum > 32767)
            sum = 32767;
        else if (sum < -32768)
            sum = -32768;
        return SAMPLE_W'(sum);
    endfunction

    function automatic mix_frame_t mix_frame(
        input logic signed [SAMPLE_W-1:0] l_in,
        input logic signed [SAMPLE_W-1:0] r_in
    );
        mix_frame_t f;
        f.left = mix_one(LEFT, l_in, regs.left_delay, regs.left_volume);
        if (regs.mono_mode)
            f.right = f.left;
        else
            f.right = mix_one(RIGHT, r_in, regs.right_delay, regs.right_volume);
        wr_ptr = (wr_ptr + 1 >= STORE_DEPTH) ? 0 : wr_ptr + 1;
        return f;
    endfunction

    // Sampled at the falling edge: these are the values the next rising edge acts on.
    always @(negedge clk)
    begin
        mix_frame_t want;
        if (!rst_n)
        begin
            regs.dry_level    = RST_DRY_LEVEL;
            regs.wet_level    = RST_WET_LEVEL;
            regs.left_delay   = RST_LEFT_DELAY;
            regs.right_delay  = RST_RIGHT_DELAY;
            regs.left_volume  = RST_LEFT_VOLUME;
            regs.right_volume = RST_RIGHT_VOLUME;
            regs.mono_mode    = 1'b0;
            regs.invert_wet   = 1'b0;
            foreach (delay_line[c, i])
                delay_line[c][i] = '0;
            wr_ptr = 0;
            expected_mix.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DRY_LEVEL:    regs.dry_level    = cfg_data[LEVEL_W-1:0];
                    REG_WET_LEVEL:    regs.wet_level    = cfg_data[LEVEL_W-1:0];
                    REG_LEFT_DELAY:   regs.left_delay   = cfg_data[DELAY_W-1:0];
                    REG_RIGHT_DELAY:  regs.right_delay  = cfg_data[DELAY_W-1:0];
                    REG_LEFT_VOLUME:  regs.left_volume  = cfg_data[VOLUME_W-1:0];
                    REG_RIGHT_VOLUME: regs.right_volume = cfg_data[VOLUME_W-1:0];
                    REG_MONO_MODE:    regs.mono_mode    = cfg_data[0];
                    REG_INVERT_WET:   regs.invert_wet   = cfg_data[0];
                    default: ;
                endcase
            end
            if (samples.valid && samples.ready)
                expected_mix.push_back(mix_frame(samples.left_sample, samples.right_sample));
            if (results.valid && results.ready)
            begin
                if (expected_mix.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result beat %0d/%0d with no frame outstanding",
                             $time, results.left_result, results.right_result);
                end
                else
                begin
                    want = expected_mix.pop_front();
                    if (results.left_result !== want.left)
                    begin
                        errors++;
                        $display("%0t ns left_result: expected %0d, got %0d",
                                 $time, want.left, results.left_result);
                    end
                    if (results.right_result !== want.right)
                    begin
                        errors++;
                        $display("%0t ns right_result: expected %0d, got %0d",
                                 $time, want.right, results.right_result);
                    end
                end
            end
        end
        pending = expected_mix.size();
    end

endmodule

// File: dv/stereo_delay_mixer_tb.sv
// Top of the stereo delay mixer bench: clock, reset, register writes, frame
// stimulus and result back-pressure, plus the verdict. Depends on sdm_pkg, the
// channel interfaces, the block and stereo_delay_mixer_checker.
`timescale 1ns / 1ps

module stereo_delay_mixer_tb;
    import sdm_pkg::*;

    localparam int STORE_DEPTH    = 750;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_FRAMES   = 66;
    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 8;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC
    } ready_style_e;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    ready_style_e          ready_style = READY_ALWAYS;
    int                    hold_requests = 0;
    int                    holds_done = 0;
    int                    idle_cycles;

    sdm_in_if  samples_if ();
    sdm_out_if results_if ();

    stereo_delay_mixer #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_if),
        .results  (results_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    stereo_delay_mixer_checker #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_if),
        .results  (results_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Holds valid until the beat; returns on the edge that took it.
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] l_val,
                              input logic signed [SAMPLE_W-1:0] r_val);
        samples_if.valid        <= 1'b1;
        samples_if.left_sample  <= l_val;
        samples_if.right_sample <= r_val;
        @(negedge clk);
        while (!samples_if.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SAMPLE_W'($urandom_range(0, 6)) - 16'sd3;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic run_frames(input int count, input int max_gap);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                send_frame(pick_sample(), pick_sample());
                sent++;
            end
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0 && sent < count)
            begin
                samples_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        samples_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(posedge clk);
    endtask

    // Bits above the register width are don't-care; fill them with noise.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val, input int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = CFG_DATA_W'((1 << width) - 1);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (val & keep) | (CFG_DATA_W'($urandom) & ~keep);
        @(posedge clk);
    endtask

    task automatic apply_setting(input cfg_t s);
        write_reg(REG_DRY_LEVEL, s.dry_level, LEVEL_W);
        write_reg(REG_WET_LEVEL, s.wet_level, LEVEL_W);
        write_reg(REG_LEFT_DELAY, CFG_DATA_W'(s.left_delay), DELAY_W);
        write_reg(REG_RIGHT_DELAY, CFG_DATA_W'(s.right_delay), DELAY_W);
        write_reg(REG_LEFT_VOLUME, CFG_DATA_W'(s.left_volume), VOLUME_W);
        write_reg(REG_RIGHT_VOLUME, CFG_DATA_W'(s.right_volume), VOLUME_W);
        write_reg(REG_MONO_MODE, CFG_DATA_W'(s.mono_mode), 1);
        write_reg(REG_INVERT_WET, CFG_DATA_W'(s.invert_wet), 1);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 10'd512;
            2: return '1;
            default: return LEVEL_W'($urandom_range(0, 512));
        endcase
    endfunction

    function automatic logic [VOLUME_W-1:0] pick_volume();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 9'd256;
            2: return '1;
            default: return VOLUME_W'($urandom_range(0, 256));
        endcase
    endfunction

    // short taps most of the time so the reads land on recent samples
    function automatic logic [DELAY_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 9'd255;
            2: return 9'd256;
            3: return '1;
            4: return DELAY_W'($urandom_range(0, 511));
            default: return DELAY_W'($urandom_range(0, 12));
        endcase
    endfunction

    // result side back-pressure
    initial
    begin
        int hold_left;
        int tick;
        hold_left = 0;
        tick = 0;
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else
            begin
                case (ready_style)
                    READY_ALWAYS: results_if.ready <= 1'b1;
                    READY_RANDOM: results_if.ready <= ($urandom_range(0, 99) < 65);
                    default:      results_if.ready <= ((tick % 9) < 5);
                endcase
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("stereo_delay_mixer: mismatch");
        $finish;
    end

    initial
    begin
        cfg_t setting;
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= '0;
        cfg_data                <= '0;
        samples_if.valid        <= 1'b0;
        samples_if.left_sample  <= '0;
        samples_if.right_sample <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: full-scale and sign-edge samples
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sd0, 16'sd0);
        send_frame(-16'sd1, 16'sd1);
        send_frame(16'sd1, -16'sd1);
        send_frame(16'sh5555, 16'shAAAA);
        samples_if.valid <= 1'b0;
        wait_drained();

        // zero tap on the left, clamped tap on the right, hot gains, inverted wet
        setting = '{dry_level: 10'd512, wet_level: 10'd1023, left_delay: 9'd0,
                    right_delay: 9'd511, left_volume: 9'd511, right_volume: 9'd128,
                    mono_mode: 1'b0, invert_wet: 1'b1};
        apply_setting(setting);
        ready_style = READY_RANDOM;
        send_frame(16'sh7FFF, 16'sh7FFF);
        send_frame(16'sh8000, 16'sh8000);
        send_frame(16'sd20000, -16'sd20000);
        send_frame(16'sd1, -16'sd1);
        send_frame(-16'sd1, 16'sd1);
        samples_if.valid <= 1'b0;
        wait_drained();

        // mono, half dry so odd negatives show truncation toward zero
        setting = '{dry_level: 10'd128, wet_level: 10'd256, left_delay: 9'd1,
                    right_delay: 9'd3, left_volume: 9'd256, right_volume: 9'd0,
                    mono_mode: 1'b1, invert_wet: 1'b0};
        apply_setting(setting);
        ready_style = READY_PERIODIC;
        send_frame(-16'sd1, 16'sd300);
        send_frame(16'sd1, -16'sd300);
        send_frame(16'sh8000, 16'sd5);
        send_frame(16'sh7FFF, -16'sd5);
        send_frame(-16'sd3, 16'sd7);
        send_frame(16'sd3, 16'sd0);
        samples_if.valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 3)
                setting = '1;
            else if (p == 5)
                setting = '0;
            else
            begin
                setting.dry_level    = pick_level();
                setting.wet_level    = pick_level();
                setting.left_delay   = pick_delay();
                setting.right_delay  = pick_delay();
                setting.left_volume  = pick_volume();
                setting.right_volume = pick_volume();
                setting.mono_mode    = ($urandom_range(0, 3) == 0);
                setting.invert_wet   = 1'($urandom_range(0, 1));
            end
            apply_setting(setting);
            ready_style = ready_style_e'(p % 3);
            if (p == 2)
            begin
                // long result stall with back-to-back frames: fills the queue
                hold_requests++;
                run_frames(PHASE_FRAMES, 0);
            end
            else
                run_frames(PHASE_FRAMES, (p % 2 == 1) ? 6 : 0);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("stereo_delay_mixer: match");
        else
            $display("stereo_delay_mixer: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/sdm_pkg.sv
rtl/sdm_in_if.sv
rtl/sdm_out_if.sv
rtl/sdm_front.sv
rtl/sdm_queue.sv
rtl/sdm_back.sv
rtl/stereo_delay_mixer.sv
dv/stereo_delay_mixer_checker.sv
dv/stereo_delay_mixer_tb.sv
